// ===== rtl/dlf_pkg.sv =====
// ----------------------------------------------------------------------------
// dlf_pkg
// Types, constants and table functions for the dense layer forward block.
// ----------------------------------------------------------------------------
package dlf_pkg;

    localparam int IN_MAX    = 16;
    localparam int OUT_MAX   = 16;
    localparam int FRAC_BITS = 12;

    localparam logic [1:0] OP_WEIGHT = 2'd0;
    localparam logic [1:0] OP_BIAS   = 2'd1;
    localparam logic [1:0] OP_INPUT  = 2'd2;

    localparam logic [1:0] CFG_ACT   = 2'd0;
    localparam logic [1:0] CFG_IN    = 2'd1;
    localparam logic [1:0] CFG_OUT   = 2'd2;

    localparam logic [2:0] ACT_LINEAR  = 3'd0;
    localparam logic [2:0] ACT_RELU    = 3'd1;
    localparam logic [2:0] ACT_TANH    = 3'd2;
    localparam logic [2:0] ACT_SIGMOID = 3'd3;
    localparam logic [2:0] ACT_ELU     = 3'd4;

    localparam int ACC_W = 40;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_RD    = 5'b00010,
        ST_MAC   = 5'b00100,
        ST_ACT   = 5'b01000,
        ST_EMIT  = 5'b10000
    } t_state;

    function automatic logic [16:0] tanh_tab(input logic [3:0] i);
        logic [16:0] r;
        case (i)
            4'd0: r = 17'd0;
            4'd1: r = 17'd30285;
            4'd2: r = 17'd49912;
            4'd3: r = 17'd59320;
            4'd4: r = 17'd63179;
            4'd5: r = 17'd64659;
            4'd6: r = 17'd65212;
            4'd7: r = 17'd65417;
            default: r = 17'd65492;
        endcase
        return r;
    endfunction

    function automatic logic [16:0] exp_tab(input logic [4:0] i);
        logic [16:0] r;
        case (i)
            5'd0:  r = 17'd65536;
            5'd1:  r = 17'd39750;
            5'd2:  r = 17'd24109;
            5'd3:  r = 17'd14623;
            5'd4:  r = 17'd8869;
            5'd5:  r = 17'd5380;
            5'd6:  r = 17'd3263;
            5'd7:  r = 17'd1979;
            5'd8:  r = 17'd1200;
            5'd9:  r = 17'd728;
            5'd10: r = 17'd442;
            5'd11: r = 17'd268;
            5'd12: r = 17'd162;
            5'd13: r = 17'd99;
            5'd14: r = 17'd60;
            5'd15: r = 17'd36;
            default: r = 17'd22;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/dense_layer_forward.sv =====
// ----------------------------------------------------------------------------
// dense_layer_forward
// Fully connected layer forward pass, Q4.12, one shared MAC, activation after
// the saturated sum.
// ----------------------------------------------------------------------------
// channel  | ports                                         | handshake
// input    | i_op i_in_index i_out_index i_value i_last_in | i_start & !o_busy
// result   | o_node_index o_node_value o_last_out          | o_valid, one cycle
// config   | i_cfg_we i_cfg_index i_cfg_data               | i_cfg_we
// A last input element starts a run of out_count nodes; each node runs a bias
// load with the first memory read ahead, one MAC a cycle through the shared
// multiplier, then rounding and activation, then output, and busy stays high
// for the whole run. Reset clears control and configuration; stores are
// undefined until written. Results cannot be stalled.
// ----------------------------------------------------------------------------
module dense_layer_forward (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  logic [1:0]          i_op,
    input  logic [3:0]          i_in_index,
    input  logic [3:0]          i_out_index,
    input  logic signed [15:0]  i_value,
    input  logic                i_last_in,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [4:0]          i_cfg_data,
    output logic                o_valid,
    output logic [3:0]          o_node_index,
    output logic signed [15:0]  o_node_value,
    output logic                o_last_out
);
    import dlf_pkg::*;

    logic signed [15:0] weight_mem [IN_MAX*OUT_MAX];
    logic signed [15:0] bias_mem   [OUT_MAX];
    logic signed [15:0] in_mem     [IN_MAX];

    t_state r_state, n_state;
    logic [2:0] r_act;
    logic [4:0] r_inc, r_outc;
    logic [3:0] r_i, n_i, r_o, n_o;
    logic [3:0] r_ic_m1, r_oc_m1;
    logic signed [15:0] r_w, r_x, r_b;
    logic signed [31:0] prod;
    logic signed [ACC_W-1:0] r_acc, n_acc;
    logic r_valid;
    logic [3:0] r_nidx;
    logic signed [15:0] r_nval;
    logic r_nlast;

    wire accept = i_start && (r_state == ST_IDLE);

    assign prod = r_w * r_x;

    // stores
    always_ff @(posedge i_clk) begin
        if (accept && i_op == OP_WEIGHT) weight_mem[{i_in_index, i_out_index}] <= i_value;
        if (accept && i_op == OP_BIAS) bias_mem[i_out_index] <= i_value;
        if (accept && i_op == OP_INPUT) in_mem[i_in_index] <= i_value;
        r_w <= weight_mem[{n_i, n_o}];
        r_x <= in_mem[n_i];
        r_b <= bias_mem[n_o];
    end

    // config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= ACT_LINEAR;
            r_inc <= 5'd1;
            r_outc <= 5'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ACT: r_act <= i_cfg_data[2:0];
                CFG_IN:  r_inc <= i_cfg_data;
                CFG_OUT: r_outc <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // rounding and saturation
    logic signed [ACC_W-1:0] rnd;
    logic signed [ACC_W-FRAC_BITS-1:0] q;
    logic signed [15:0] sat;
    always_comb begin
        rnd = r_acc + ACC_W'(1 <<< (FRAC_BITS-1));
        q = rnd[ACC_W-1:FRAC_BITS];
        if (q > 32767) sat = 16'sh7fff;
        else if (q < -32768) sat = -16'sh8000;
        else sat = q[15:0];
    end

    // activation
    logic [15:0] mag;
    logic [3:0] tix;
    logic [4:0] eix;
    logic [11:0] fr;
    logic [12:0] span;
    logic [16:0] ta, tb, pw;
    logic [29:0] ip;
    logic [17:0] t2;
    logic [16:0] rr;
    logic signed [15:0] act;
    always_comb begin
        mag = sat[15] ? 16'(-sat) : sat;
        tix = 4'd8; eix = 5'd16; fr = '0; span = 13'd2048;
        ta = '0; tb = '0; pw = '0; ip = '0; t2 = '0; rr = '0;
        act = sat;
        case (r_act)
            ACT_RELU: act = sat[15] ? 16'sd0 : sat;
            ACT_TANH, ACT_ELU: begin
                span = 13'd2048;
                fr = {1'b0, mag[10:0]};
                if (r_act == ACT_TANH) begin
                    tix = (mag[15:11] >= 5'd8) ? 4'd8 : mag[14:11];
                    ta = tanh_tab(tix);
                    tb = tanh_tab(tix + 4'd1);
                    if (mag[15:11] >= 5'd8) begin ta = tanh_tab(4'd8); fr = '0; end
                end else begin
                    eix = (mag[15:11] >= 5'd16) ? 5'd16 : mag[15:11];
                    ta = exp_tab(eix);
                    tb = exp_tab(eix + 5'd1);
                    if (mag[15:11] >= 5'd16) begin ta = exp_tab(5'd16); fr = '0; end
                end
                ip = 30'(ta) * 30'(span - 13'(fr)) + 30'(tb) * 30'(fr);
                pw = ip[27:11];
                if (r_act == ACT_TANH) begin
                    rr = 17'((18'(pw) + 18'd8) >> 4);
                    act = sat[15] ? -16'(rr) : 16'(rr);
                end else if (!sat[15] && sat != 0) begin
                    act = sat;
                end else begin
                    rr = 17'((18'(17'd65536 - pw) + 18'd8) >> 4);
                    act = -16'(rr);
                end
            end
            ACT_SIGMOID: begin
                span = 13'd4096;
                tix = (mag[15:12] >= 4'd8) ? 4'd8 : mag[15:12];
                fr = mag[11:0];
                ta = tanh_tab(tix);
                tb = tanh_tab(tix + 4'd1);
                if (mag[15:12] >= 4'd8) begin ta = tanh_tab(4'd8); fr = '0; end
                ip = 30'(ta) * 30'(span - 13'(fr)) + 30'(tb) * 30'(fr);
                pw = ip[28:12];
                t2 = sat[15] ? 18'(18'd65536 - 18'(pw)) : 18'(18'd65536 + 18'(pw));
                rr = 17'((t2 + 18'd16) >> 5);
                act = 16'(rr);
            end
            default: act = sat;
        endcase
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_i = r_i;
        n_o = r_o;
        n_acc = r_acc;
        case (r_state)
            ST_IDLE: begin
                n_i = '0; n_o = '0;
                if (accept && i_op == OP_INPUT && i_last_in) n_state = ST_RD;
            end
            ST_RD: begin
                n_acc = ACC_W'(r_b) <<< FRAC_BITS;
                n_state = ST_MAC;
            end
            ST_MAC: begin
                n_acc = r_acc + ACC_W'(prod);
                if (r_i == r_ic_m1) n_state = ST_ACT;
                else n_i = r_i + 4'd1;
            end
            ST_ACT: n_state = ST_EMIT;
            ST_EMIT: begin
                n_i = '0;
                if (r_o == r_oc_m1) n_state = ST_IDLE;
                else begin
                    n_o = r_o + 4'd1;
                    n_state = ST_RD;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
            r_i <= '0;
            r_o <= '0;
        end else begin
            r_state <= n_state;
            r_i <= n_i;
            r_o <= n_o;
            r_valid <= (r_state == ST_ACT);
        end
        r_acc <= n_acc;
        if (accept) begin
            r_ic_m1 <= (r_inc == 0) ? 4'd0 : (r_inc > 5'd16) ? 4'd15 : 4'(r_inc - 5'd1);
            r_oc_m1 <= (r_outc == 0) ? 4'd0 : (r_outc > 5'd16) ? 4'd15 : 4'(r_outc - 5'd1);
        end
        if (r_state == ST_ACT) begin
            r_nidx <= r_o;
            r_nval <= act;
            r_nlast <= (r_o == r_oc_m1);
        end
    end

    assign o_busy = (r_state != ST_IDLE);
    assign o_valid = r_valid;
    assign o_node_index = r_nidx;
    assign o_node_value = r_nval;
    assign o_last_out = r_nlast;

    a_valid_after_act: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == ST_ACT))
        else $error("result without activation step");
    a_busy_on_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_op == OP_INPUT && i_last_in) |=> o_busy)
        else $error("run did not start");
    a_no_valid_idle_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_out) |=> !o_busy)
        else $error("busy after last result");
endmodule
